@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

  // Width of one stored value and of the key carried with each command.
  localparam int unsigned ValueWidth = 32;

  // Default number of cells in the sorted store.
  localparam int unsigned DefaultDepth = 16;

  // Widths of the reported result fields.
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned PositionWidth = 4;
  localparam int unsigned CountWidth    = 5;

  // Payload widths of the two streams, padded to whole bytes.
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 48;

  // Command codes. The upper bit alone selects find, so code three also finds.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [StatusWidth-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Control broadcast to every cell in the chain.
  typedef struct packed {
    logic                         ins;  // shift toward the tail and place key
    logic                         rem;  // close the gap at the first match
    logic signed [ValueWidth-1:0] key;
  } spq_ctrl_t;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// A result appears on the master side in the cycle after its command is taken.
// Throughput: one transaction per cycle; every cell compares against the key in
// parallel; an insert or remove shifts the tail side by one place in the same edge.
// The output register refills in the cycle it is read, so a stall only holds the input.
// Reset (synchronous, active high) empties the store and drops any pending result;
// the cell contents are not cleared.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // command [1:0], value [33:2], zero padding [39:34]
  input  logic [spq_pkg::InDataWidth-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // status [1:0], position [5:2], head_value [37:6], empty_res [38],
  // entry_count [43:39], zero padding [47:44]
  output logic [spq_pkg::OutDataWidth-1:0]     m_tdata
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  // Input fields.
  logic [1:0]                   command;
  logic signed [ValueWidth-1:0] key;
  logic                         accept;

  assign command  = s_tdata[1:0];
  assign key      = s_tdata[ValueWidth+1:2];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Fill count and the cell chain.
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         full;
  logic                         found;
  logic                         is_ins;
  logic                         is_rem;
  spq_ctrl_t                    ctrl;

  logic signed [ValueWidth-1:0] cell_value      [DEPTH];
  logic signed [ValueWidth-1:0] cell_value_next [DEPTH];
  logic [DEPTH-1:0]             cell_ge;
  logic [DEPTH-1:0]             cell_first;
  logic [DEPTH-1:0]             cell_occ;

  assign full = (count == CW'(DEPTH));

  // Command decode; the upper bit selects find.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (command)
      CMD_INSERT: is_ins = 1'b1;
      CMD_REMOVE: is_rem = 1'b1;
      default:    ;
    endcase
  end

  assign found    = |cell_first;
  assign ctrl.ins = accept && is_ins && !full;
  assign ctrl.rem = accept && is_rem && found;
  assign ctrl.key = key;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [ValueWidth-1:0] prev_value;
      logic                         prev_ge;
      logic signed [ValueWidth-1:0] next_value;

      assign cell_occ[gi] = (CW'(gi) < count);

      if (gi == 0) begin : g_head
        assign prev_value = cell_value[gi];
        assign prev_ge    = 1'b0;
      end else begin : g_mid
        assign prev_value = cell_value[gi-1];
        assign prev_ge    = cell_ge[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign next_value = cell_value[gi];
      end else begin : g_body
        assign next_value = cell_value[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (cell_occ[gi]),
        .prev_value (prev_value),
        .prev_ge    (prev_ge),
        .next_value (next_value),
        .value      (cell_value[gi]),
        .value_next (cell_value_next[gi]),
        .ge         (cell_ge[gi]),
        .first      (cell_first[gi])
      );
    end
  endgenerate

  // Encode the one-hot first match into an index.
  logic [IW-1:0] hit_idx;
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | (cell_first[i] ? IW'(i) : '0);
    end
  end

  // Next count.
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result fields for the accepted command.
  status_t                      res_status;
  logic [IW-1:0]                res_idx;
  logic [IW+PositionWidth-1:0]  pos_wide;
  logic [CW+CountWidth-1:0]     cnt_wide;

  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    if (is_ins) begin
      if (full) begin
        res_status = ST_FULL;
      end
    end else if (!found) begin
      res_status = ST_MISS;
    end else begin
      res_idx = hit_idx;
    end
  end

  assign pos_wide = {{PositionWidth{1'b0}}, res_idx};
  assign cnt_wide = {{CountWidth{1'b0}}, count_next};

  // Output register.
  status_t                      out_status;
  logic [PositionWidth-1:0]     out_position;
  logic signed [ValueWidth-1:0] out_head;
  logic                         out_empty;
  logic [CountWidth-1:0]        out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status   <= res_status;
      out_position <= pos_wide[PositionWidth-1:0];
      out_head     <= (count_next == '0) ? '0 : cell_value_next[0];
      out_empty    <= (count_next == '0);
      out_count    <= cnt_wide[CountWidth-1:0];
    end
  end

  assign m_tdata = {4'b0, out_count, out_empty, out_head, out_position, out_status};

  // The count never passes the number of cells.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  // An insert into a full store leaves the count unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_ins && full) |=> (count == $past(count)))
    else $error("dropped insert changed the count");

  // A successful remove takes exactly one entry away.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.rem |=> (count == $past(count) - 1'b1))
    else $error("remove did not decrement the count");

  // At most one cell claims the first match.
  assert property (@(posedge clk) disable iff (rst) $onehot0(cell_first))
    else $error("several first-match cells");

  // A command that leaves the store empty reports the empty flag and a zero head.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (count_next == '0)) |=> (out_empty && (out_head == '0)))
    else $error("empty result carries a head value");

endmodule

@@ hw/rtl/spq_cell.sv @@
module spq_cell (
  input  logic                                 clk,
  input  spq_pkg::spq_ctrl_t                   ctrl,
  input  logic                                 occ,        // cell lies below the count
  input  logic signed [spq_pkg::ValueWidth-1:0] prev_value, // neighbor toward the head
  input  logic                                 prev_ge,
  input  logic signed [spq_pkg::ValueWidth-1:0] next_value, // neighbor toward the tail
  output logic signed [spq_pkg::ValueWidth-1:0] value,
  output logic signed [spq_pkg::ValueWidth-1:0] value_next,
  output logic                                 ge,
  output logic                                 first
);
  import spq_pkg::*;

  logic eq;

  // Empty cells count as greater or equal, so a key above the rest lands at the tail.
  assign ge    = !occ || (value >= ctrl.key);
  assign eq    = occ && (value == ctrl.key);
  // The first match is the matching cell whose head-side neighbor is smaller.
  assign first = eq && !prev_ge;

  // Pick the new contents from this cell, its neighbors or the key.
  always_comb begin
    value_next = value;
    if (ctrl.ins) begin
      if (prev_ge) begin
        value_next = prev_value;
      end else if (ge) begin
        value_next = ctrl.key;
      end
    end else if (ctrl.rem && ge) begin
      value_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
